### design/pet_pkg.sv
// package for the partition extent table
// item types, configuration, slot entry layout, status and action codes, sequencer states
// no dependencies
`timescale 1ns / 1ps

package pet_pkg;

    localparam int ADDR_W  = 48;
    localparam int SLOT_W  = 7;
    localparam int COUNT_W = 8;

    localparam logic [1:0] ACT_CREATE = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_FIND   = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD      = 3'd1;
    localparam logic [2:0] ST_OVERLAP  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NO_GAP   = 3'd4;

    localparam logic [1:0] CFG_LOWEST_BLOCK  = 2'd0;
    localparam logic [1:0] CFG_HIGHEST_BLOCK = 2'd1;
    localparam logic [1:0] CFG_SLOTS_IN_USE  = 2'd2;
    localparam logic [1:0] CFG_TABLE_VALID   = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] start_block;
        logic [ADDR_W-1:0] end_block;
        logic [SLOT_W-1:0] slot_number;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot_taken;
        logic [ADDR_W-1:0] gap_start;
        logic [ADDR_W-1:0] gap_end;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  lowest_block;
        logic [ADDR_W-1:0]  highest_block;
        logic [COUNT_W-1:0] slots_in_use;
        logic               table_valid;
    } t_cfg;

    typedef struct packed {
        logic              used;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
    } t_entry;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_C_SCAN,
        S_C_DONE,
        S_D_CHECK,
        S_F_SCAN,
        S_F_GAP,
        S_F_BEST,
        S_F_END,
        S_OUT
    } t_state;

endpackage

### design/pet_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/pet_engine.sv
// command sequencer of the partition extent table: slot memory, scans and gap walk
// depends on pet_pkg and pet_ram
`timescale 1ns / 1ps

module pet_engine
    import pet_pkg::*;
#(
    parameter int MAX_SLOTS = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int KW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int DW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int EW = $bits(t_entry);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [IW-1:0]     r_pidx, n_pidx;
    t_in_item          r_item, n_item;
    logic              r_overlap, n_overlap;
    logic              r_free_ok, n_free_ok;
    logic [IW-1:0]     r_free_idx, n_free_idx;
    logic              r_found, n_found;
    logic [ADDR_W-1:0] r_pick_first, n_pick_first;
    logic [ADDR_W-1:0] r_pick_last, n_pick_last;
    logic [ADDR_W-1:0] r_cursor, n_cursor;
    logic              r_gap, n_gap;
    logic [ADDR_W-1:0] r_gap_hi, n_gap_hi;
    logic [ADDR_W-1:0] r_gap_len, n_gap_len;
    logic              r_have, n_have;
    logic [ADDR_W-1:0] r_best_a, n_best_a;
    logic [ADDR_W-1:0] r_best_b, n_best_b;
    logic [ADDR_W-1:0] r_best_len, n_best_len;
    t_out_item         r_res, n_res;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;
    t_entry        rd_entry;

    logic [KW-1:0] siu_ext;
    logic [CW-1:0] cnt;
    logic [DW-1:0] del_ext;
    logic [DW-1:0] cnt_ext;
    logic          scan_done;

    pet_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SLOTS),
        .AW    (IW)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry  = t_entry'(ram_rdata);
    assign siu_ext   = KW'(i_cfg.slots_in_use);
    assign cnt       = (siu_ext > KW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(siu_ext);
    assign del_ext   = DW'(i_in_item.slot_number);
    assign cnt_ext   = DW'(cnt);
    assign scan_done = (r_idx == cnt) && !r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx       <= n_pidx;
        r_item       <= n_item;
        r_overlap    <= n_overlap;
        r_free_ok    <= n_free_ok;
        r_free_idx   <= n_free_idx;
        r_found      <= n_found;
        r_pick_first <= n_pick_first;
        r_pick_last  <= n_pick_last;
        r_cursor     <= n_cursor;
        r_gap        <= n_gap;
        r_gap_hi     <= n_gap_hi;
        r_gap_len    <= n_gap_len;
        r_have       <= n_have;
        r_best_a     <= n_best_a;
        r_best_b     <= n_best_b;
        r_best_len   <= n_best_len;
        r_res        <= n_res;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pend       = 1'b0;
        n_pidx       = r_pidx;
        n_item       = r_item;
        n_overlap    = r_overlap;
        n_free_ok    = r_free_ok;
        n_free_idx   = r_free_idx;
        n_found      = r_found;
        n_pick_first = r_pick_first;
        n_pick_last  = r_pick_last;
        n_cursor     = r_cursor;
        n_gap        = r_gap;
        n_gap_hi     = r_gap_hi;
        n_gap_len    = r_gap_len;
        n_have       = r_have;
        n_best_a     = r_best_a;
        n_best_b     = r_best_b;
        n_best_len   = r_best_len;
        n_res        = r_res;
        ram_we       = 1'b0;
        ram_waddr    = r_idx[IW-1:0];
        ram_wdata    = '0;
        ram_raddr    = r_idx[IW-1:0];
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[IW-1:0];
                n_idx     = r_idx + CW'(1);
                if (r_idx == CW'(MAX_SLOTS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item    = i_in_item;
                    n_res     = '0;
                    n_idx     = '0;
                    n_overlap = 1'b0;
                    n_free_ok = 1'b0;
                    n_found   = 1'b0;
                    case (i_in_item.action)
                        ACT_CREATE: begin
                            if (!i_cfg.table_valid ||
                                i_in_item.start_block < i_cfg.lowest_block ||
                                i_in_item.end_block > i_cfg.highest_block ||
                                i_in_item.start_block > i_in_item.end_block) begin
                                n_res.status = ST_BAD;
                                n_state      = S_OUT;
                            end else begin
                                n_state = S_C_SCAN;
                            end
                        end
                        ACT_DELETE: begin
                            if (del_ext < cnt_ext) begin
                                ram_raddr = del_ext[IW-1:0];
                                n_pidx    = del_ext[IW-1:0];
                                n_state   = S_D_CHECK;
                            end else begin
                                n_res.status = ST_BAD;
                                n_state      = S_OUT;
                            end
                        end
                        ACT_FIND: begin
                            n_cursor   = i_cfg.lowest_block;
                            n_have     = 1'b0;
                            n_best_a   = '0;
                            n_best_b   = '0;
                            n_best_len = '0;
                            n_state    = S_F_SCAN;
                        end
                        default: begin
                            n_res.status = ST_BAD;
                            n_state      = S_OUT;
                        end
                    endcase
                end
            end

            S_C_SCAN: begin
                if (r_idx != cnt) begin
                    ram_raddr = r_idx[IW-1:0];
                    n_pidx    = r_idx[IW-1:0];
                    n_idx     = r_idx + CW'(1);
                    n_pend    = 1'b1;
                end
                if (r_pend) begin
                    if (rd_entry.used && r_item.start_block <= rd_entry.last &&
                        rd_entry.first <= r_item.end_block) begin
                        n_overlap = 1'b1;
                    end
                    if (!rd_entry.used && !r_free_ok) begin
                        n_free_ok  = 1'b1;
                        n_free_idx = r_pidx;
                    end
                end
                if (scan_done) begin
                    n_state = S_C_DONE;
                end
            end

            S_C_DONE: begin
                if (r_overlap) begin
                    n_res.status = ST_OVERLAP;
                end else if (r_free_ok) begin
                    ram_we           = 1'b1;
                    ram_waddr        = r_free_idx;
                    ram_wdata.used   = 1'b1;
                    ram_wdata.first  = r_item.start_block;
                    ram_wdata.last   = r_item.end_block;
                    n_res.status     = ST_OK;
                    n_res.slot_taken = SLOT_W'(r_free_idx);
                end else begin
                    n_res.status = ST_FULL;
                end
                n_state = S_OUT;
            end

            S_D_CHECK: begin
                if (rd_entry.used) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_pidx;
                    n_res.status = ST_OK;
                end else begin
                    n_res.status = ST_BAD;
                end
                n_state = S_OUT;
            end

            S_F_SCAN: begin
                if (r_idx != cnt) begin
                    ram_raddr = r_idx[IW-1:0];
                    n_idx     = r_idx + CW'(1);
                    n_pend    = 1'b1;
                end
                if (r_pend) begin
                    if (rd_entry.used && rd_entry.first >= r_cursor &&
                        rd_entry.first <= i_cfg.highest_block &&
                        (!r_found || rd_entry.first < r_pick_first)) begin
                        n_found      = 1'b1;
                        n_pick_first = rd_entry.first;
                        n_pick_last  = rd_entry.last;
                    end
                end
                if (scan_done) begin
                    n_state = S_F_GAP;
                end
            end

            S_F_GAP: begin
                if (r_found) begin
                    n_gap    = r_pick_first > r_cursor;
                    n_gap_hi = r_pick_first - ADDR_W'(1);
                end else begin
                    n_gap    = r_cursor <= i_cfg.highest_block;
                    n_gap_hi = i_cfg.highest_block;
                end
                n_gap_len = n_gap_hi - r_cursor;
                n_state   = S_F_BEST;
            end

            S_F_BEST: begin
                if (r_gap && (!r_have || r_gap_len > r_best_len)) begin
                    n_have     = 1'b1;
                    n_best_a   = r_cursor;
                    n_best_b   = r_gap_hi;
                    n_best_len = r_gap_len;
                end
                if (!r_found || (&r_pick_last)) begin
                    n_state = S_F_END;
                end else begin
                    n_cursor = r_pick_last + ADDR_W'(1);
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_state  = S_F_SCAN;
                end
            end

            S_F_END: begin
                if (r_have) begin
                    n_res.status    = ST_OK;
                    n_res.gap_start = r_best_a;
                    n_res.gap_end   = r_best_b;
                end else begin
                    n_res.status = ST_NO_GAP;
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_item = r_res;

endmodule

### design/partition_extent_table.sv
// Partition extent table: one command item in, one result item out. State is held in a
// single slot memory (used mark, first and last block) with one read and one write port,
// and the create and find scans are worked through that read port one slot a cycle. A find
// runs the gap walk in rounds, at most the number of used extents walked plus one; a bad
// range or an unknown action is answered without a scan. One command is in flight at a
// time. After reset a clearing pass writes every slot empty before the first item is
// taken; configuration writes are accepted throughout.
// depends on pet_pkg and pet_engine
`timescale 1ns / 1ps

module partition_extent_table
    import pet_pkg::*;
#(
    parameter int MAX_SLOTS = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lowest_block  <= ADDR_W'(34);
            r_cfg.highest_block <= '0;
            r_cfg.slots_in_use  <= COUNT_W'(128);
            r_cfg.table_valid   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOWEST_BLOCK:  r_cfg.lowest_block  <= i_cfg_data;
                CFG_HIGHEST_BLOCK: r_cfg.highest_block <= i_cfg_data;
                CFG_SLOTS_IN_USE:  r_cfg.slots_in_use  <= i_cfg_data[COUNT_W-1:0];
                CFG_TABLE_VALID:   r_cfg.table_valid   <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    pet_engine #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### tb/sv/partition_extent_table_tb.sv
// testbench for partition_extent_table: a directed table of commands, then randomised
// phases of settings and commands, each result checked against a stated or modelled value
// depends on pet_pkg and partition_extent_table
`timescale 1ns / 1ps

module partition_extent_table_tb;
    import pet_pkg::*;

    localparam int TABLE_SLOTS = 128;
    localparam int RANDOM_ITEMS = 1350;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};
    localparam bit KNOWN = 1'b1;
    localparam bit PREDICT = 1'b0;

    typedef struct {
        bit                is_reg;
        logic [1:0]        reg_idx;
        logic [ADDR_W-1:0] reg_data;
        t_in_item          cmd;
        bit                known;
        t_out_item         want;
    } t_plan_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [ADDR_W-1:0] i_cfg_data = '0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // model of the table and its settings
    logic [ADDR_W-1:0]  cfg_first = 48'd34;
    logic [ADDR_W-1:0]  cfg_last = '0;
    logic [COUNT_W-1:0] cfg_slots = 8'd128;
    logic               cfg_valid = 1'b0;
    bit                 tbl_used [TABLE_SLOTS];
    logic [ADDR_W-1:0]  tbl_first [TABLE_SLOTS];
    logic [ADDR_W-1:0]  tbl_last [TABLE_SLOTS];

    t_out_item awaited_results [$];
    t_plan_row plan_rows [$];
    t_out_item want_res;
    int        fail_count = 0;
    int        results_seen = 0;
    int        send_gap_pct = 35;

    partition_extent_table #(
        .MAX_SLOTS(TABLE_SLOTS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item(o_out_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] v;
        v = rand64();
        return v[ADDR_W-1:0];
    endfunction

    function automatic int idle_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    endfunction

    function automatic int active_slots();
        return (cfg_slots > TABLE_SLOTS) ? TABLE_SLOTS : int'(cfg_slots);
    endfunction

    // applies one command to the model table and returns its result
    function automatic t_out_item table_outcome(input t_in_item c);
        t_out_item   r;
        int          n;
        int          pick;
        bit          hit, have, found, gap, stop;
        logic [63:0] cursor, gap_hi, best_a, best_b;
        r = '0;
        n = active_slots();
        case (c.action)
            ACT_CREATE: begin
                if (!cfg_valid || c.start_block < cfg_first || c.end_block > cfg_last ||
                    c.start_block > c.end_block) begin
                    r.status = ST_BAD;
                end else begin
                    hit = 1'b0;
                    for (int i = 0; i < n; i++)
                        if (tbl_used[i] && c.start_block <= tbl_last[i] &&
                            tbl_first[i] <= c.end_block)
                            hit = 1'b1;
                    if (hit) begin
                        r.status = ST_OVERLAP;
                    end else begin
                        r.status = ST_FULL;
                        for (int i = 0; i < n && r.status == ST_FULL; i++)
                            if (!tbl_used[i]) begin
                                tbl_used[i] = 1'b1;
                                tbl_first[i] = c.start_block;
                                tbl_last[i] = c.end_block;
                                r.status = ST_OK;
                                r.slot_taken = 7'(i);
                            end
                    end
                end
            end
            ACT_DELETE: begin
                if (c.slot_number >= n || !tbl_used[c.slot_number]) begin
                    r.status = ST_BAD;
                end else begin
                    tbl_used[c.slot_number] = 1'b0;
                    r.status = ST_OK;
                end
            end
            ACT_FIND: begin
                cursor = 64'(cfg_first);
                have = 1'b0;
                stop = 1'b0;
                best_a = '0;
                best_b = '0;
                // walk extents in address order from the cursor
                for (int rounds = 0; rounds <= TABLE_SLOTS && !stop; rounds++) begin
                    found = 1'b0;
                    pick = 0;
                    gap = 1'b0;
                    gap_hi = '0;
                    for (int i = 0; i < n; i++)
                        if (tbl_used[i] && tbl_first[i] >= cursor && tbl_first[i] <= cfg_last &&
                            (!found || tbl_first[i] < tbl_first[pick])) begin
                            found = 1'b1;
                            pick = i;
                        end
                    if (found) begin
                        if (tbl_first[pick] > cursor) begin
                            gap = 1'b1;
                            gap_hi = 64'(tbl_first[pick]) - 64'd1;
                        end
                    end else if (cursor <= cfg_last) begin
                        gap = 1'b1;
                        gap_hi = 64'(cfg_last);
                    end
                    if (gap && (!have || gap_hi - cursor > best_b - best_a)) begin
                        have = 1'b1;
                        best_a = cursor;
                        best_b = gap_hi;
                    end
                    if (!found || tbl_last[pick] == ADDR_TOP)
                        stop = 1'b1;
                    else
                        cursor = 64'(tbl_last[pick]) + 64'd1;
                end
                if (have) begin
                    r.status = ST_OK;
                    r.gap_start = best_a[ADDR_W-1:0];
                    r.gap_end = best_b[ADDR_W-1:0];
                end else begin
                    r.status = ST_NO_GAP;
                end
            end
            default: r.status = ST_BAD;
        endcase
        return r;
    endfunction

    function automatic void plan_cmd(input logic [1:0] act, input logic [ADDR_W-1:0] s,
                                     input logic [ADDR_W-1:0] e, input logic [SLOT_W-1:0] slot,
                                     input bit known, input logic [2:0] st,
                                     input logic [SLOT_W-1:0] taken,
                                     input logic [ADDR_W-1:0] ga, input logic [ADDR_W-1:0] gb);
        t_plan_row row;
        row.is_reg = 1'b0;
        row.reg_idx = '0;
        row.reg_data = '0;
        row.cmd = '{action: act, start_block: s, end_block: e, slot_number: slot};
        row.known = known;
        row.want = '{status: st, slot_taken: taken, gap_start: ga, gap_end: gb};
        plan_rows.push_back(row);
    endfunction

    function automatic void plan_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] data);
        t_plan_row row;
        row.is_reg = 1'b1;
        row.reg_idx = idx;
        row.reg_data = data;
        row.cmd = '0;
        row.known = 1'b0;
        row.want = '0;
        plan_rows.push_back(row);
    endfunction

    // random command, mostly well formed against the current table
    function automatic t_in_item make_cmd();
        t_in_item    c;
        int          n, roll;
        int          cand [$];
        logic [63:0] span, s64, len;
        n = active_slots();
        c.action = ACT_FIND;
        c.start_block = rand_addr();
        c.end_block = rand_addr();
        c.slot_number = 7'($urandom_range(0, 127));
        for (int i = 0; i < n; i++)
            if (tbl_used[i])
                cand.push_back(i);
        span = (cfg_last >= cfg_first) ? 64'(cfg_last) - 64'(cfg_first) : 64'd0;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            c.action = 2'($urandom_range(0, 3));
        end else if (roll < 55) begin
            c.action = ACT_CREATE;
            if (cand.size() != 0 && $urandom_range(0, 4) == 0)
                s64 = 64'(tbl_first[cand[$urandom_range(0, cand.size() - 1)]]) +
                      64'($urandom_range(0, 5));
            else
                s64 = 64'(cfg_first) + rand64() % (span + 64'd1);
            len = ($urandom_range(0, 4) == 0) ? rand64() % (span / 4 + 64'd1) :
                                                 64'($urandom_range(0, 40));
            c.start_block = s64[ADDR_W-1:0];
            c.end_block = 48'(s64 + len);
        end else if (roll < 75) begin
            c.action = ACT_DELETE;
            if (cand.size() != 0 && $urandom_range(0, 9) < 7)
                c.slot_number = 7'(cand[$urandom_range(0, cand.size() - 1)]);
        end
        return c;
    endfunction

    task automatic send_cmd(input t_in_item c, input bit known, input t_out_item want);
        t_out_item predicted;
        @(negedge i_clk);
        if ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat (idle_len()) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= c;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = table_outcome(c);
        awaited_results.push_back(known ? want : predicted);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LOWEST_BLOCK:  cfg_first = data;
            CFG_HIGHEST_BLOCK: cfg_last = data;
            CFG_SLOTS_IN_USE:  cfg_slots = data[COUNT_W-1:0];
            CFG_TABLE_VALID:   cfg_valid = data[0];
            default: ;
        endcase
    endtask

    task automatic choose_settings();
        logic [63:0]        lo, hi;
        logic [COUNT_W-1:0] count;
        int                 mode;
        mode = $urandom_range(0, 7);
        if (mode == 0) begin
            lo = '0;
            hi = 64'(ADDR_TOP);
        end else if (mode == 1) begin
            lo = 64'(rand_addr());
            hi = 64'(rand_addr());
        end else if (mode == 7) begin
            lo = 64'(ADDR_TOP) - 64'($urandom_range(0, 50));
            hi = 64'(ADDR_TOP);
        end else begin
            lo = ($urandom_range(0, 3) == 0) ? 64'(rand_addr() >> $urandom_range(0, 47)) :
                                               64'($urandom_range(0, 100));
            hi = lo + 64'($urandom_range(16, 2000));
            if (hi > 64'(ADDR_TOP))
                hi = 64'(ADDR_TOP);
        end
        // mostly few active slots, now and then the whole table or more
        case ($urandom_range(0, 19))
            0: count = 8'd0;
            1: count = 8'd128;
            2: count = 8'd255;
            3: count = 8'($urandom_range(129, 254));
            default: count = 8'($urandom_range(1, 12));
        endcase
        write_reg(CFG_LOWEST_BLOCK, lo[ADDR_W-1:0]);
        write_reg(CFG_HIGHEST_BLOCK, hi[ADDR_W-1:0]);
        write_reg(CFG_SLOTS_IN_USE, 48'(count));
        write_reg(CFG_TABLE_VALID, 48'($urandom_range(0, 7) != 0));
        send_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 35;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                fail_count++;
                $display("%0t: result with none awaited: status %0d slot %0d gap %h..%h",
                         $time, o_out_item.status, o_out_item.slot_taken,
                         o_out_item.gap_start, o_out_item.gap_end);
            end else begin
                want_res = awaited_results.pop_front();
                if (o_out_item.status !== want_res.status ||
                    o_out_item.slot_taken !== want_res.slot_taken ||
                    o_out_item.gap_start !== want_res.gap_start ||
                    o_out_item.gap_end !== want_res.gap_end) begin
                    fail_count++;
                    if (fail_count <= 200)
                        $display("%0t: mismatch: expected status %0d slot %0d gap %h..%h, %s",
                                 $time, want_res.status, want_res.slot_taken,
                                 want_res.gap_start, want_res.gap_end,
                                 $sformatf("got status %0d slot %0d gap %h..%h",
                                           o_out_item.status, o_out_item.slot_taken,
                                           o_out_item.gap_start, o_out_item.gap_end));
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off while the sender keeps offering
    initial begin
        bit held_off;
        int stretch;
        held_off = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!held_off && results_seen >= 300 && i_in_valid) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600) :
                                                    $urandom_range(1, 40);
            repeat (stretch) @(negedge i_clk);
            if ($urandom_range(0, 1) == 0) begin
                i_out_ready <= 1'b0;
                repeat (idle_len()) @(negedge i_clk);
            end
        end
    end

    initial begin
        int sent;
        int n_items;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            tbl_used[i] = 1'b0;
            tbl_first[i] = '0;
            tbl_last[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // after reset: range empty, table not valid
        plan_cmd(ACT_FIND, 0, 0, 0, KNOWN, ST_NO_GAP, 0, 0, 0);
        plan_cmd(ACT_CREATE, 34, 40, 0, KNOWN, ST_BAD, 0, 0, 0);
        plan_cmd(ACT_DELETE, 0, 0, 0, KNOWN, ST_BAD, 0, 0, 0);
        plan_cmd(ACT_UNUSED, ADDR_TOP, ADDR_TOP, 127, KNOWN, ST_BAD, 0, 0, 0);
        plan_reg(CFG_HIGHEST_BLOCK, 1000);
        plan_reg(CFG_TABLE_VALID, 1);
        plan_reg(CFG_SLOTS_IN_USE, 4);
        plan_cmd(ACT_FIND, 0, 0, 0, KNOWN, ST_OK, 0, 34, 1000);
        plan_cmd(ACT_CREATE, 33, 40, 0, KNOWN, ST_BAD, 0, 0, 0);
        plan_cmd(ACT_CREATE, 100, 1001, 0, KNOWN, ST_BAD, 0, 0, 0);
        plan_cmd(ACT_CREATE, 200, 100, 0, KNOWN, ST_BAD, 0, 0, 0);
        plan_cmd(ACT_CREATE, 34, 34, 0, KNOWN, ST_OK, 0, 0, 0);
        plan_cmd(ACT_CREATE, 1000, 1000, 0, KNOWN, ST_OK, 1, 0, 0);
        plan_cmd(ACT_CREATE, 34, 50, 0, KNOWN, ST_OVERLAP, 0, 0, 0);
        plan_cmd(ACT_CREATE, 500, 600, 0, KNOWN, ST_OK, 2, 0, 0);
        plan_cmd(ACT_CREATE, 300, 310, 0, KNOWN, ST_OK, 3, 0, 0);
        plan_cmd(ACT_CREATE, 700, 700, 0, KNOWN, ST_FULL, 0, 0, 0);
        plan_cmd(ACT_FIND, 0, 0, 0, PREDICT, ST_OK, 0, 0, 0);
        plan_cmd(ACT_DELETE, 0, 0, 3, KNOWN, ST_OK, 0, 0, 0);
        plan_cmd(ACT_DELETE, 0, 0, 3, KNOWN, ST_BAD, 0, 0, 0);
        plan_cmd(ACT_DELETE, 0, 0, 4, KNOWN, ST_BAD, 0, 0, 0);
        // whole address space, extent up to the top address
        plan_reg(CFG_LOWEST_BLOCK, 0);
        plan_reg(CFG_HIGHEST_BLOCK, ADDR_TOP);
        plan_cmd(ACT_CREATE, 0, ADDR_TOP, 0, KNOWN, ST_OVERLAP, 0, 0, 0);
        plan_cmd(ACT_CREATE, 48'hFFFF_FFFF_FFF0, ADDR_TOP, 0, KNOWN, ST_OK, 3, 0, 0);
        plan_cmd(ACT_FIND, 0, 0, 0, PREDICT, ST_OK, 0, 0, 0);
        // two gaps of equal size, stored extents outside the range
        plan_reg(CFG_LOWEST_BLOCK, 35);
        plan_reg(CFG_HIGHEST_BLOCK, 1465);
        plan_cmd(ACT_FIND, 0, 0, 0, PREDICT, ST_OK, 0, 0, 0);
        plan_reg(CFG_SLOTS_IN_USE, 0);
        plan_cmd(ACT_CREATE, 1100, 1100, 0, KNOWN, ST_FULL, 0, 0, 0);
        plan_cmd(ACT_DELETE, 0, 0, 0, KNOWN, ST_BAD, 0, 0, 0);
        plan_reg(CFG_SLOTS_IN_USE, 255);
        plan_cmd(ACT_DELETE, 0, 0, 127, KNOWN, ST_BAD, 0, 0, 0);
        plan_cmd(ACT_FIND, 0, 0, 0, PREDICT, ST_OK, 0, 0, 0);

        foreach (plan_rows[k]) begin
            if (plan_rows[k].is_reg) begin
                settle();
                write_reg(plan_rows[k].reg_idx, plan_rows[k].reg_data);
            end else begin
                send_cmd(plan_rows[k].cmd, plan_rows[k].known, plan_rows[k].want);
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            choose_settings();
            n_items = $urandom_range(30, 80);
            repeat (n_items) begin
                send_cmd(make_cmd(), PREDICT, '0);
                sent++;
            end
        end

        settle();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #1_000_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
